[sv/crs_pkg.sv]
// Shared constants, types and helper functions of the CV range splitter.
`timescale 1ns / 1ps
package crs_pkg;

	localparam int NUM_OUT = 6;
	localparam int CNT_W = 3;          // holds 0..NUM_OUT
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int VOLT_W = 16;
	localparam int OUT_W = 15;
	localparam int Q12_W = 13;
	localparam int T_W = 13;
	localparam int BND_W = 29;         // segment start and width, volt * 4096 * n scale
	localparam int REM_W = 30;         // divider remainder
	localparam int DIV_STEPS = 13;
	localparam int DIV_PER_STG = 2;
	localparam int DIV_STG = 7;

	localparam logic [Q12_W-1:0] Q12_ONE = 13'd4096;
	localparam logic [OUT_W-1:0] OUT_FULL = 15'd20480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OVERLAP_KNOB       = 3'd0,
		CFG_SMOOTH_KNOB        = 3'd1,
		CFG_OVERLAP_FROM_CV    = 3'd2,
		CFG_SMOOTH_FROM_CV     = 3'd3,
		CFG_OUTPUT_ENABLE_MASK = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic en;
		logic below;
		logic above;
	} lane_flags_t;

	// CV saturated to 0..10 V, then (2c+5)/10 via reciprocal multiply
	function automatic logic [Q12_W-1:0] cv_to_frac(input logic signed [VOLT_W-1:0] c);
		logic [14:0] cs;
		logic [15:0] num;
		logic [31:0] prod;
		if (c < 0)
			cs = '0;
		else if (c > 16'sd20480)
			cs = 15'd20480;
		else
			cs = c[14:0];
		num = {cs, 1'b0} + 16'd5;
		prod = 32'(num) * 32'd52429;
		return prod[31:19];
	endfunction

	function automatic logic [Q12_W-1:0] knob_to_frac(input logic [Q12_W-1:0] k);
		return (k > Q12_ONE) ? Q12_ONE : k;
	endfunction

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
			input logic [BND_W-1:0] d, input logic shift);
		logic [REM_W:0] r2;
		logic [REM_W:0] dif;
		logic bit_q;
		r2 = shift ? {r, 1'b0} : {1'b0, r};
		bit_q = (r2 >= {2'b0, d});
		dif = r2 - {2'b0, d};
		return bit_q ? {1'b1, dif[REM_W-1:0]} : {1'b0, r2[REM_W-1:0]};
	endfunction

endpackage

[sv/cv_range_splitter_smootherstep.sv]
// CV range splitter: spreads one CV over six outputs with smootherstep blending.
`timescale 1ns / 1ps
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the knob,
//   source-select and output-enable registers; cfg_ready is always high and
//   indexes past the last register are dropped. Write it only while idle.
//   Input channel (in_valid/in_ready) carries cv_in, overlap_cv and
//   smooth_cv; output channel (out_valid/out_ready) carries out_one..out_six.
// Timing:
//   16-stage pipeline with a registered output. One item per cycle sustained
//   while out_ready stays high; the depth is set by the 13-bit restoring
//   divider (two steps per stage) and the smootherstep multiplies.
// Stalls:
//   Each stage has its own valid bit and loads when it is empty or the next
//   stage moves, so bubbles collapse and nothing is lost or repeated while
//   out_ready is low. in_ready drops only when every stage is full.
// Reset:
//   arst_n clears the config registers to zero (no outputs enabled) and empties the pipe.
//
module cv_range_splitter_smootherstep import crs_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [VOLT_W-1:0]   cv_in,
	input  logic signed [VOLT_W-1:0]   overlap_cv,
	input  logic signed [VOLT_W-1:0]   smooth_cv,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [OUT_W-1:0]           out_one,
	output logic [OUT_W-1:0]           out_two,
	output logic [OUT_W-1:0]           out_three,
	output logic [OUT_W-1:0]           out_four,
	output logic [OUT_W-1:0]           out_five,
	output logic [OUT_W-1:0]           out_six
);

	localparam int NSTG = DIV_STG + 9;
	localparam int DIV_FIRST = 4;

	// ---------------- configuration ----------------
	logic [Q12_W-1:0]   overlap_knob_q;
	logic [Q12_W-1:0]   smooth_knob_q;
	logic               overlap_from_cv_q;
	logic               smooth_from_cv_q;
	logic [NUM_OUT-1:0] enable_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_knob_q    <= '0;
			smooth_knob_q     <= '0;
			overlap_from_cv_q <= 1'b0;
			smooth_from_cv_q  <= 1'b0;
			enable_mask_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OVERLAP_KNOB:       overlap_knob_q    <= cfg_data;
				CFG_SMOOTH_KNOB:        smooth_knob_q     <= cfg_data;
				CFG_OVERLAP_FROM_CV:    overlap_from_cv_q <= cfg_data[0];
				CFG_SMOOTH_FROM_CV:     smooth_from_cv_q  <= cfg_data[0];
				CFG_OUTPUT_ENABLE_MASK: enable_mask_q     <= cfg_data[NUM_OUT-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage flow control ----------------
	logic [NSTG:1]   stg_vld_q;
	logic [NSTG+1:1] adv;
	logic [NSTG:0]   vld_chain;

	assign vld_chain = {stg_vld_q, in_valid};

	always_comb begin
		adv[NSTG+1] = out_ready;
		for (int i = NSTG; i >= 1; i--)
			adv[i] = !stg_vld_q[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			for (int i = 1; i <= NSTG; i++)
				if (adv[i])
					stg_vld_q[i] <= vld_chain[i-1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = stg_vld_q[NSTG];

	// ---------------- stage 1: fractions, lane numbering ----------------
	logic [Q12_W-1:0] ov_c, sm_c;
	logic [CNT_W-1:0] k_c [NUM_OUT];
	logic [CNT_W-1:0] n_c;

	always_comb begin
		ov_c = overlap_from_cv_q ? cv_to_frac(overlap_cv) : knob_to_frac(overlap_knob_q);
		sm_c = smooth_from_cv_q ? cv_to_frac(smooth_cv) : knob_to_frac(smooth_knob_q);
		n_c = '0;
		for (int i = 0; i < NUM_OUT; i++) begin
			k_c[i] = n_c;
			if (enable_mask_q[i])
				n_c = n_c + 1'b1;
		end
	end

	logic signed [VOLT_W-1:0] v_s1;
	logic [Q12_W-1:0]         ov_s1, sm_s1;
	logic [CNT_W-1:0]         n_s1;
	logic [CNT_W-1:0]         k_s1 [NUM_OUT];
	logic [NUM_OUT-1:0]       en_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			v_s1  <= cv_in;
			ov_s1 <= ov_c;
			sm_s1 <= sm_c;
			n_s1  <= n_c;
			k_s1  <= k_c;
			en_s1 <= enable_mask_q;
		end
	end

	// ---------------- stage 2: scaled input, segment bounds ----------------
	logic signed [19:0] vn_c;
	logic signed [31:0] vs_c;
	logic [CNT_W-1:0]   nm1_c;
	logic [14:0]        w_c;
	logic [BND_W-1:0]   d_c;
	logic [BND_W-1:0]   lo_c [NUM_OUT];
	logic [Q12_W-1:0]   ovc_c;
	logic [14:0]        kov_c;

	always_comb begin
		vn_c  = 20'(v_s1 * $signed({1'b0, n_s1}));
		vs_c  = {vn_c, 12'b0};
		nm1_c = (n_s1 == '0) ? '0 : n_s1 - 1'b1;
		w_c   = 15'(nm1_c * ov_s1) + 15'(Q12_ONE);
		d_c   = {17'(({2'b0, w_c} << 2) + {2'b0, w_c}), 12'b0};
		ovc_c = Q12_ONE - ov_s1;
		for (int i = 0; i < NUM_OUT; i++) begin
			kov_c    = 15'(k_s1[i] * ovc_c);
			lo_c[i]  = {17'(({2'b0, kov_c} << 2) + {2'b0, kov_c}), 12'b0};
		end
	end

	logic signed [31:0] vs_s2;
	logic [BND_W-1:0]   d_s2;
	logic [BND_W-1:0]   lo_s2 [NUM_OUT];
	logic [Q12_W-1:0]   sm_s2;
	logic [NUM_OUT-1:0] en_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			vs_s2 <= vs_c;
			d_s2  <= d_c;
			lo_s2 <= lo_c;
			sm_s2 <= sm_s1;
			en_s2 <= en_s1;
		end
	end

	// ---------------- stage 3: range test, offset into segment ----------------
	lane_flags_t      flg_c [NUM_OUT];
	logic [REM_W-1:0] x_c   [NUM_OUT];

	always_comb begin
		logic signed [31:0] lo_x, hi_x, dif;
		for (int i = 0; i < NUM_OUT; i++) begin
			lo_x = $signed({3'b0, lo_s2[i]});
			hi_x = lo_x + $signed({3'b0, d_s2});
			dif  = vs_s2 - lo_x;
			flg_c[i].en    = en_s2[i];
			flg_c[i].below = (vs_s2 < lo_x);
			flg_c[i].above = (vs_s2 > hi_x);
			x_c[i] = dif[REM_W-1:0];
		end
	end

	lane_flags_t      flg_s3 [NUM_OUT];
	logic [REM_W-1:0] x_s3   [NUM_OUT];
	logic [BND_W-1:0] d_s3;
	logic [Q12_W-1:0] sm_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			flg_s3 <= flg_c;
			x_s3   <= x_c;
			d_s3   <= d_s2;
			sm_s3  <= sm_s2;
		end
	end

	// ---------------- stages 4..10: restoring divider, t = x*4096/d ----------------
	logic [REM_W-1:0] div_rem_sd [DIV_STG][NUM_OUT];
	logic [T_W-1:0]   div_q_sd   [DIV_STG][NUM_OUT];
	lane_flags_t      div_flg_sd [DIV_STG][NUM_OUT];
	logic [BND_W-1:0] div_d_sd   [DIV_STG];
	logic [Q12_W-1:0] div_sm_sd  [DIV_STG];

	for (genvar g = 0; g < DIV_STG; g++) begin : g_div
		logic [REM_W-1:0] src_rem [NUM_OUT];
		logic [T_W-1:0]   src_q   [NUM_OUT];
		lane_flags_t      src_flg [NUM_OUT];
		logic [BND_W-1:0] src_d;
		logic [Q12_W-1:0] src_sm;
		logic [REM_W-1:0] nxt_rem [NUM_OUT];
		logic [T_W-1:0]   nxt_q   [NUM_OUT];

		if (g == 0) begin : g_head
			always_comb begin
				src_rem = x_s3;
				src_flg = flg_s3;
				src_d   = d_s3;
				src_sm  = sm_s3;
				for (int i = 0; i < NUM_OUT; i++)
					src_q[i] = '0;
			end
		end else begin : g_body
			always_comb begin
				src_rem = div_rem_sd[g-1];
				src_q   = div_q_sd[g-1];
				src_flg = div_flg_sd[g-1];
				src_d   = div_d_sd[g-1];
				src_sm  = div_sm_sd[g-1];
			end
		end

		always_comb begin
			logic [REM_W:0] st;
			int j;
			nxt_rem = src_rem;
			nxt_q   = src_q;
			for (int i = 0; i < NUM_OUT; i++) begin
				for (int s = 0; s < DIV_PER_STG; s++) begin
					j = g * DIV_PER_STG + s;
					if (j < DIV_STEPS) begin
						// first step only tests the unshifted offset (t can reach 4096)
						st = div_step(nxt_rem[i], src_d, j != 0);
						nxt_q[i]   = {nxt_q[i][T_W-2:0], st[REM_W]};
						nxt_rem[i] = st[REM_W-1:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[DIV_FIRST+g]) begin
				div_rem_sd[g] <= nxt_rem;
				div_q_sd[g]   <= nxt_q;
				div_flg_sd[g] <= src_flg;
				div_d_sd[g]   <= src_d;
				div_sm_sd[g]  <= src_sm;
			end
		end
	end

	// ---------------- stage 11: t^2, 15*4096*t ----------------
	localparam int S11 = DIV_FIRST + DIV_STG;

	logic [T_W-1:0]   t_s11   [NUM_OUT];
	logic [24:0]      t2_s11  [NUM_OUT];
	logic [27:0]      m15_s11 [NUM_OUT];
	lane_flags_t      flg_s11 [NUM_OUT];
	logic [Q12_W-1:0] sm_s11;

	always_ff @(posedge clk) begin
		if (adv[S11]) begin
			for (int i = 0; i < NUM_OUT; i++) begin
				t_s11[i]   <= div_q_sd[DIV_STG-1][i];
				t2_s11[i]  <= 25'(div_q_sd[DIV_STG-1][i] * div_q_sd[DIV_STG-1][i]);
				m15_s11[i] <= 28'(div_q_sd[DIV_STG-1][i] * 16'd61440);
			end
			flg_s11 <= div_flg_sd[DIV_STG-1];
			sm_s11  <= div_sm_sd[DIV_STG-1];
		end
	end

	// ---------------- stage 12: polynomial, t^3 ----------------
	logic [T_W-1:0]   t_s12    [NUM_OUT];
	logic [27:0]      poly_s12 [NUM_OUT];
	logic [36:0]      t3_s12   [NUM_OUT];
	lane_flags_t      flg_s12  [NUM_OUT];
	logic [Q12_W-1:0] sm_s12;

	always_ff @(posedge clk) begin
		if (adv[S11+1]) begin
			for (int i = 0; i < NUM_OUT; i++) begin
				t_s12[i]    <= t_s11[i];
				poly_s12[i] <= 28'(29'(t2_s11[i] * 3'd6) + 29'd167772160 - 29'(m15_s11[i]));
				t3_s12[i]   <= 37'(t2_s11[i] * t_s11[i]);
			end
			flg_s12 <= flg_s11;
			sm_s12  <= sm_s11;
		end
	end

	// ---------------- stage 13: split product t^3 * poly ----------------
	logic [T_W-1:0]   t_s13   [NUM_OUT];
	logic [50:0]      plo_s13 [NUM_OUT];
	logic [50:0]      phi_s13 [NUM_OUT];
	lane_flags_t      flg_s13 [NUM_OUT];
	logic [Q12_W-1:0] sm_s13;

	always_ff @(posedge clk) begin
		if (adv[S11+2]) begin
			for (int i = 0; i < NUM_OUT; i++) begin
				t_s13[i]   <= t_s12[i];
				plo_s13[i] <= 51'(t3_s12[i] * poly_s12[i][13:0]);
				phi_s13[i] <= 51'(t3_s12[i] * poly_s12[i][27:14]);
			end
			flg_s13 <= flg_s12;
			sm_s13  <= sm_s12;
		end
	end

	// ---------------- stage 14: sum and round to Q12 ----------------
	logic [T_W-1:0] s_c [NUM_OUT];

	always_comb begin
		logic [61:0] s5;
		for (int i = 0; i < NUM_OUT; i++) begin
			s5 = 62'(plo_s13[i]) + {phi_s13[i][47:0], 14'b0} + (62'd1 << 47);
			s_c[i] = s5[60:48];
		end
	end

	logic [T_W-1:0]   t_s14   [NUM_OUT];
	logic [T_W-1:0]   s_s14   [NUM_OUT];
	lane_flags_t      flg_s14 [NUM_OUT];
	logic [Q12_W-1:0] sm_s14;

	always_ff @(posedge clk) begin
		if (adv[S11+3]) begin
			t_s14   <= t_s13;
			s_s14   <= s_c;
			flg_s14 <= flg_s13;
			sm_s14  <= sm_s13;
		end
	end

	// ---------------- stage 15: (s - t) * smoothness ----------------
	logic [T_W-1:0]     t_s15    [NUM_OUT];
	logic signed [27:0] prod_s15 [NUM_OUT];
	lane_flags_t        flg_s15  [NUM_OUT];

	always_ff @(posedge clk) begin
		if (adv[S11+4]) begin
			for (int i = 0; i < NUM_OUT; i++) begin
				t_s15[i]    <= t_s14[i];
				prod_s15[i] <= 28'(($signed({1'b0, s_s14[i]}) - $signed({1'b0, t_s14[i]}))
					* $signed({1'b0, sm_s14}));
			end
			flg_s15 <= flg_s14;
		end
	end

	// ---------------- stage 16: blend, scale to volts, output register ----------------
	logic [OUT_W-1:0] out_c [NUM_OUT];

	always_comb begin
		logic signed [27:0] b;
		logic [24:0]        bpos;
		logic [27:0]        val;
		for (int i = 0; i < NUM_OUT; i++) begin
			b    = $signed({3'b0, t_s15[i], 12'b0}) + prod_s15[i];
			bpos = (b < 0) ? '0 : b[24:0];
			val  = 28'(bpos * 3'd5) + 28'd2048;
			if (!flg_s15[i].en || flg_s15[i].below)
				out_c[i] = '0;
			else if (flg_s15[i].above)
				out_c[i] = OUT_FULL;
			else
				out_c[i] = val[26:12];
		end
	end

	logic [OUT_W-1:0] out_s16 [NUM_OUT];

	always_ff @(posedge clk) begin
		if (adv[NSTG])
			out_s16 <= out_c;
	end

	assign out_one   = out_s16[0];
	assign out_two   = out_s16[1];
	assign out_three = out_s16[2];
	assign out_four  = out_s16[3];
	assign out_five  = out_s16[4];
	assign out_six   = out_s16[5];

endmodule

[tb/sv/crs_checker.sv]
// Checker for the CV range splitter: predicts each result and compares it with the output.
`timescale 1ns / 1ps
module crs_checker import crs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [VOLT_W-1:0] cv_in,
	input  logic signed [VOLT_W-1:0] overlap_cv,
	input  logic signed [VOLT_W-1:0] smooth_cv,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [OUT_W-1:0]         out_one,
	input  logic [OUT_W-1:0]         out_two,
	input  logic [OUT_W-1:0]         out_three,
	input  logic [OUT_W-1:0]         out_four,
	input  logic [OUT_W-1:0]         out_five,
	input  logic [OUT_W-1:0]         out_six,
	output int                       err_count,
	output int                       pending,
	output int                       result_count
);

	typedef logic [NUM_OUT-1:0][OUT_W-1:0] level_set_t;

	logic [12:0] ov_knob, sm_knob;
	logic        ov_sel_cv, sm_sel_cv;
	logic [5:0]  en_mask;
	level_set_t  level_q[$];

	function automatic longint sat_cv_frac(input logic signed [VOLT_W-1:0] c);
		longint cc;
		cc = c;
		if (cc < 0) cc = 0;
		if (cc > 20480) cc = 20480;
		return (cc * 2 + 5) / 10;
	endfunction

	function automatic logic [OUT_W-1:0] lane_level(input longint v, input longint k,
			input longint n, input longint ov, input longint sm);
		longint vs, lo, hi, t, s, b;
		longint unsigned tu, poly, s5, r;
		vs = v * 4096 * n;
		lo = 64'sd20480 * k * (4096 - ov);
		hi = 64'sd20480 * ((k + 1) * 4096 + (n - k - 1) * ov);
		if (vs < lo) return '0;
		if (vs > hi) return OUT_FULL;
		t = ((vs - lo) * 4096) / (hi - lo);
		if (t > 4096) t = 4096;
		tu = t;
		poly = 64'd6 * tu * tu + 64'd167772160 - 64'd61440 * tu;
		s5 = tu * tu * tu * poly;
		s = longint'((s5 + (64'd1 << 47)) >> 48);
		b = t * 4096 + (s - t) * sm;
		if (b < 0) b = 0;
		r = ((longint'(b) * 5) + 2048) >> 12;
		return r[OUT_W-1:0];
	endfunction

	function automatic level_set_t split_levels(input logic signed [VOLT_W-1:0] v,
			input logic signed [VOLT_W-1:0] ocv, input logic signed [VOLT_W-1:0] scv);
		longint ov, sm, n, k;
		level_set_t res;
		ov = ov_sel_cv ? sat_cv_frac(ocv) : ((ov_knob > 4096) ? 4096 : ov_knob);
		sm = sm_sel_cv ? sat_cv_frac(scv) : ((sm_knob > 4096) ? 4096 : sm_knob);
		n = $countones(en_mask);
		k = 0;
		for (int i = 0; i < NUM_OUT; i++) begin
			if (en_mask[i]) begin
				res[i] = lane_level(v, k, n, ov, sm);
				k++;
			end else begin
				res[i] = '0;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		level_set_t got, want;
		if (!arst_n) begin
			ov_knob <= '0;
			sm_knob <= '0;
			ov_sel_cv <= 1'b0;
			sm_sel_cv <= 1'b0;
			en_mask <= '0;
			level_q.delete();
			err_count <= 0;
			pending <= 0;
			result_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_OVERLAP_KNOB: ov_knob <= cfg_data;
					CFG_SMOOTH_KNOB: sm_knob <= cfg_data;
					CFG_OVERLAP_FROM_CV: ov_sel_cv <= cfg_data[0];
					CFG_SMOOTH_FROM_CV: sm_sel_cv <= cfg_data[0];
					CFG_OUTPUT_ENABLE_MASK: en_mask <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				level_q.push_back(split_levels(cv_in, overlap_cv, smooth_cv));
			if (out_valid && out_ready) begin
				got = {out_six, out_five, out_four, out_three, out_two, out_one};
				result_count <= result_count + 1;
				if (level_q.size() == 0) begin
					if (err_count < 10)
						$display("unexpected output transfer: %p", got);
					err_count <= err_count + 1;
				end else begin
					want = level_q.pop_front();
					if (got !== want) begin
						if (err_count < 10)
							for (int i = 0; i < NUM_OUT; i++)
								if (got[i] !== want[i])
									$display("out %0d mismatch: expected %0d got %0d",
										i + 1, want[i], got[i]);
						err_count <= err_count + 1;
					end
				end
			end
			pending <= level_q.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top: drives stimulus and config for the CV range splitter and reports the verdict.
`timescale 1ns / 1ps
module tb_top import crs_pkg::*;;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [VOLT_W-1:0] cv_in, overlap_cv, smooth_cv;
	logic [OUT_W-1:0] out_one, out_two, out_three, out_four, out_five, out_six;
	int err_count, pending, result_count, cycles, burst_left, sent;

	cv_range_splitter_smootherstep u_top (.*);
	crs_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** cv_range_splitter_smootherstep: FAILED **");
			$finish;
		end
	end

	// receiver stall pattern: switches between free-running, choppy and mostly-stalled
	int stall_mode, mode_left;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int d);
		logic ok;
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(d);
		forever begin
			#1 ok = cfg_ready;
			@(posedge clk);
			if (ok) break;
			@(negedge clk);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (pending != 0 || u_top.out_valid === 1'b1) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(input int ovk, input int smk, input bit ovc, input bit smc,
			input int mask);
		drain();
		write_reg(CFG_OVERLAP_KNOB, ovk);
		write_reg(CFG_SMOOTH_KNOB, smk);
		write_reg(CFG_OVERLAP_FROM_CV, ovc);
		write_reg(CFG_SMOOTH_FROM_CV, smc);
		write_reg(CFG_OUTPUT_ENABLE_MASK, mask);
	endtask

	task automatic push(input int v, input int ocv, input int scv);
		logic ok;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		in_valid = 1'b1;
		cv_in = VOLT_W'(v);
		overlap_cv = VOLT_W'(ocv);
		smooth_cv = VOLT_W'(scv);
		forever begin
			#1 ok = in_ready;
			@(posedge clk);
			if (ok) break;
			@(negedge clk);
		end
		sent++;
	endtask

	function automatic int rand_cv();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 20480);
			default: return $urandom_range(0, 24000) - 2000;
		endcase
	endfunction

	initial begin
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; cv_in = '0; overlap_cv = '0; smooth_cv = '0;
		burst_left = 0; sent = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset state: nothing enabled
		push(16'h7FFF, 0, 0);
		push(16'h8000, 16'h7FFF, 16'h8000);
		// directed: full and partial output masks, extremes of every field and bound-ish voltages
		set_mode(0, 0, 0, 0, 6'h3F);
		push(16'h8000, 0, 0); push(16'h7FFF, 0, 0); push(0, 0, 0);
		push(20480, 0, 0); push(3413, 0, 0); push(3414, 0, 0); push(10240, 0, 0);
		set_mode(8191, 8191, 0, 0, 6'h3F);
		push(10240, 0, 0); push(0, 0, 0); push(20480, 0, 0); push(17000, 0, 0);
		set_mode(4096, 4096, 1, 1, 6'h25);
		push(10240, 16'h8000, 16'h7FFF); push(10240, 16'h7FFF, 16'h8000);
		push(5000, 20480, 20480); push(5000, 0, 0); push(5000, 10239, 10241);
		set_mode(2048, 1024, 0, 1, 6'h01);
		push(0, 0, 20480); push(20480, 0, 0); push(7777, 0, 15000);
		drain();
		write_reg(CFG_UNUSED, 13'h1FFF);
		push(12000, 0, 0);

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			set_mode(($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096),
				($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096),
				$urandom_range(0, 1), $urandom_range(0, 1),
				(ph == 0) ? 6'h3F : $urandom_range(0, 63));
			if (ph == 5) write_reg(CFG_UNUSED, $urandom());
			for (int i = 0; i < 140; i++)
				push(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 22528) - 1024,
					rand_cv(), rand_cv());
		end
		drain();

		$display("sent %0d samples, checked %0d output sets over 17 register settings",
			sent, result_count);
		$display("covered knob and CV sources, saturation, masks and receiver stalls");
		if (err_count == 0 && pending == 0)
			$display("** cv_range_splitter_smootherstep: PASSED **");
		else
			$display("** cv_range_splitter_smootherstep: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/crs_pkg.sv
sv/cv_range_splitter_smootherstep.sv
tb/sv/crs_checker.sv
tb/sv/tb_top.sv
